### src/raa_pkg.sv
// Shared types, codes and widths for the rational accumulator.
package raa_pkg;

    // Default and wide datapath widths
    localparam int WIDTH_DEF = 32;
    localparam int WIDE_W    = 64;

    // Command codes
    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_NEG  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] opnd_numerator;
        logic [30:0]        opnd_denominator;
    } op_t;

    typedef struct packed {
        logic signed [31:0] acc_num_out;
        logic [30:0]        acc_den_out;
        logic               is_less;
        logic               is_greater;
        logic               is_equal;
        logic [1:0]         status;
    } res_t;

endpackage

### src/raa_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface raa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/rational_arithmetic_accumulator_top.sv
// Rational accumulator top level: sequencer, shared multiplier, gcd and divider units.
//
//   channel  dir  payload  handshake
//   op       in   op_t     valid/ready, beat taken when both high
//   res      out  res_t    valid/ready, beat taken when both high
//
// One item at a time: four products on the multiplier, a form step, the
// binary gcd over 64-bit magnitudes, the dual divider and the post of the
// result. A zero denominator, a zero divisor numerator on a divide or an
// unused command skips from the form step to the post.
// Reset sets the accumulator to 0/1 and empties the result register.
// A new op beat is taken while the previous result still waits on res.
module rational_arithmetic_accumulator_top import raa_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    raa_stream_if.sink   op,
    raa_stream_if.source res
);

    localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (WIDTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_FORM, S_GCD, S_DIV, S_DONE} state_t;

    state_t                    state_reg;
    logic [1:0]                mcnt_reg;
    logic [2:0]                cmd_reg;
    logic signed [31:0]        on_reg;
    logic [30:0]               od_reg;
    logic signed [31:0]        acc_num_reg;
    logic [30:0]               acc_den_reg;
    logic signed [WIDE_W-1:0]  prod_reg [4];
    logic                      lt_reg;
    logic                      gt_reg;
    logic                      eq_reg;
    logic [1:0]                status_reg;
    logic                      neg_reg;
    logic [WIDE_W-1:0]         nm_reg;
    logic [WIDE_W-1:0]         dm_reg;
    logic                      res_valid_reg;
    res_t                      res_data_reg;

    logic signed [32:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [65:0]        mul_p;
    logic signed [65:0]        n_form;
    logic signed [65:0]        d_form;
    logic signed [65:0]        n_abs;
    logic                      err_zero;
    logic                      no_op;
    logic                      gcd_start;
    logic                      gcd_done;
    logic [WIDE_W-1:0]         gcd_g;
    logic                      div_start;
    logic                      div_done;
    logic [WIDE_W-1:0]         rn;
    logic [WIDE_W-1:0]         rd;
    logic [WIDE_W-1:0]         rn_neg;
    logic                      ovf;

    // Pick multiplier operands for the current product slot
    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:
            begin
                mul_a = {acc_num_reg[31], acc_num_reg};
                mul_b = {2'b00, od_reg};
            end
            2'd1:
            begin
                mul_a = {on_reg[31], on_reg};
                mul_b = {2'b00, acc_den_reg};
            end
            2'd2:
            begin
                mul_a = {2'b00, acc_den_reg};
                mul_b = {2'b00, od_reg};
            end
            default:
            begin
                mul_a = {acc_num_reg[31], acc_num_reg};
                mul_b = {on_reg[31], on_reg};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Form the unreduced numerator and denominator
    always_comb
    begin
        n_form = 66'sd0;
        d_form = 66'sd1;
        case (cmd_reg)
            CMD_LOAD:
            begin
                n_form = 66'(on_reg);
                d_form = {35'd0, od_reg};
            end
            CMD_ADD:
            begin
                n_form = 66'(prod_reg[0]) + 66'(prod_reg[1]);
                d_form = 66'(prod_reg[2]);
            end
            CMD_SUB:
            begin
                n_form = 66'(prod_reg[0]) - 66'(prod_reg[1]);
                d_form = 66'(prod_reg[2]);
            end
            CMD_MUL:
            begin
                n_form = 66'(prod_reg[3]);
                d_form = 66'(prod_reg[2]);
            end
            CMD_DIV:
            begin
                if (prod_reg[1] < 0)
                begin
                    n_form = -66'(prod_reg[0]);
                    d_form = -66'(prod_reg[1]);
                end
                else
                begin
                    n_form = 66'(prod_reg[0]);
                    d_form = 66'(prod_reg[1]);
                end
            end
            CMD_NEG:
            begin
                n_form = -66'(acc_num_reg);
                d_form = {35'd0, acc_den_reg};
            end
            default:
            begin
                n_form = 66'sd0;
                d_form = 66'sd1;
            end
        endcase
        n_abs = (n_form < 0) ? -n_form : n_form;
    end

    assign err_zero = ((cmd_reg <= CMD_DIV) && (od_reg == '0)) ||
                      ((cmd_reg == CMD_DIV) && (on_reg == '0));
    assign no_op     = (cmd_reg > CMD_NEG);
    assign gcd_start = (state_reg == S_FORM) && !err_zero && !no_op;
    assign div_start = (state_reg == S_GCD) && gcd_done;

    // Range check of the reduced fraction
    assign rn_neg = -rn;
    assign ovf    = (rd >= LIM) || (neg_reg ? (rn > LIM) : (rn >= LIM));

    raa_gcd #(.W(WIDE_W)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a_in  (n_abs[WIDE_W-1:0]),
        .b_in  (d_form[WIDE_W-1:0]),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    raa_div #(.W(WIDE_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_a (nm_reg),
        .num_b (dm_reg),
        .den   (gcd_g),
        .done  (div_done),
        .quo_a (rn),
        .quo_b (rd)
    );

    // Sequence one item and hold the accumulator and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mcnt_reg      <= '0;
            acc_num_reg   <= '0;
            acc_den_reg   <= 31'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a post, drop it once the beat is taken
            if ((state_reg == S_DONE) && (!res_valid_reg || res.ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (op.valid)
                    begin
                        cmd_reg   <= op.data.cmd;
                        on_reg    <= op.data.opnd_numerator;
                        od_reg    <= op.data.opnd_denominator;
                        mcnt_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg[mcnt_reg] <= mul_p[WIDE_W-1:0];
                    mcnt_reg           <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 2'd3)
                    begin
                        state_reg <= S_FORM;
                    end
                end
                S_FORM:
                begin
                    lt_reg     <= (od_reg != '0) && (prod_reg[0] < prod_reg[1]);
                    gt_reg     <= (od_reg != '0) && (prod_reg[0] > prod_reg[1]);
                    eq_reg     <= (od_reg != '0) && (prod_reg[0] == prod_reg[1]);
                    neg_reg    <= (n_form < 0);
                    nm_reg     <= n_abs[WIDE_W-1:0];
                    dm_reg     <= d_form[WIDE_W-1:0];
                    status_reg <= err_zero ? ST_ZERO : ST_OK;
                    state_reg  <= (err_zero || no_op) ? S_DONE : S_GCD;
                end
                S_GCD:
                begin
                    if (gcd_done)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (ovf)
                        begin
                            status_reg <= ST_OVF;
                        end
                        else
                        begin
                            acc_num_reg <= neg_reg ? rn_neg[31:0] : rn[31:0];
                            acc_den_reg <= rd[30:0];
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Post the result once the output register is free
                    if (!res_valid_reg || res.ready)
                    begin
                        res_data_reg.acc_num_out <= acc_num_reg;
                        res_data_reg.acc_den_out <= acc_den_reg;
                        res_data_reg.is_less     <= lt_reg;
                        res_data_reg.is_greater  <= gt_reg;
                        res_data_reg.is_equal    <= eq_reg;
                        res_data_reg.status      <= status_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign op.ready  = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

`ifndef SYNTH
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        acc_den_reg != '0)
        else $error("accumulator denominator is zero");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid && op.ready |=> !op.ready)
        else $error("second op beat taken while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.data.status == ST_OK || res.data.status == ST_ZERO ||
                       res.data.status == ST_OVF))
        else $error("undefined status code");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_done |-> gcd_g != '0)
        else $error("gcd unit returned zero");
`endif

endmodule

### src/raa_gcd.sv
// Binary gcd unit: one subtract or shift per cycle, then restores common powers of two.
module raa_gcd import raa_pkg::*; #(
    parameter int W = WIDE_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic [W-1:0] g
);

    localparam int KW = $clog2(W);

    typedef enum logic [1:0] {G_IDLE, G_RUN, G_SHIFT} gstate_t;

    gstate_t       state_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [KW-1:0] k_reg;
    logic          done_reg;
    logic [W:0]    a_minus_b;
    logic [W-1:0]  b_minus_a;

    // Compare and difference of the two odd values
    assign a_minus_b = {1'b0, a_reg} - {1'b0, b_reg};
    assign b_minus_a = b_reg - a_reg;

    // Step the reduction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            done_reg <= (state_reg == G_SHIFT) && (k_reg == '0);
            unique case (state_reg)
                G_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a_in;
                        b_reg     <= b_in;
                        k_reg     <= '0;
                        state_reg <= G_RUN;
                    end
                end
                G_RUN:
                begin
                    if (b_reg == '0)
                    begin
                        state_reg <= G_SHIFT;
                    end
                    else if (a_reg == '0)
                    begin
                        a_reg     <= b_reg;
                        state_reg <= G_SHIFT;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    else if (!a_minus_b[W])
                    begin
                        a_reg <= a_minus_b[W-1:0];
                    end
                    else
                    begin
                        b_reg <= b_minus_a;
                    end
                end
                G_SHIFT:
                begin
                    // Restore the common factor of two one bit a cycle
                    if (k_reg == '0)
                    begin
                        state_reg <= G_IDLE;
                    end
                    else
                    begin
                        a_reg <= a_reg << 1;
                        k_reg <= k_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign g    = a_reg;

endmodule

### src/raa_div.sv
// Dual restoring divider: two dividends over one divisor, one quotient bit per cycle.
module raa_div import raa_pkg::*; #(
    parameter int W = WIDE_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num_a,
    input  logic [W-1:0] num_b,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo_a,
    output logic [W-1:0] quo_b
);

    localparam int CW = $clog2(W);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t       state_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  qa_reg;
    logic [W-1:0]  qb_reg;
    logic [W-1:0]  ra_reg;
    logic [W-1:0]  rb_reg;
    logic [W:0]    sha;
    logic [W:0]    shb;
    logic [W:0]    da;
    logic [W:0]    db;

    // Trial subtract for both partial remainders
    assign sha = {ra_reg, qa_reg[W-1]};
    assign shb = {rb_reg, qb_reg[W-1]};
    assign da  = sha - {1'b0, den_reg};
    assign db  = shb - {1'b0, den_reg};

    // Shift one quotient bit into each register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_RUN) && (cnt_reg == CW'(W - 1));
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        den_reg   <= den;
                        qa_reg    <= num_a;
                        qb_reg    <= num_b;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    ra_reg <= da[W] ? sha[W-1:0] : da[W-1:0];
                    rb_reg <= db[W] ? shb[W-1:0] : db[W-1:0];
                    qa_reg <= {qa_reg[W-2:0], ~da[W]};
                    qb_reg <= {qb_reg[W-2:0], ~db[W]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1))
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;

endmodule
